// ===== rtl/abc_pkg.sv =====
package abc_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 16;

  localparam int DATA_BITS = CHANNELS * SAMPLE_BITS;
  localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;

  localparam int HOLD_W    = 16;
  localparam int CRUSH_W   = 5;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CRUSH_BITS  = CFG_IDX_W'(1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Quotient width of the divider, rounded up so that two bits retire per cycle.
  localparam int QUO_BITS = SAMPLE_BITS + (SAMPLE_BITS % 2);
  localparam int DIV_CYC  = QUO_BITS / 2;
  localparam int DIV_CW   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

endpackage

// ===== rtl/abc_front.sv =====
module abc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [abc_pkg::HOLD_W-1:0]        hold_period,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  abc_pkg::frame_t                   in_frame,
  input  logic                              q_full,
  output logic                              q_push,
  output abc_pkg::frame_t                   q_frame
);

  logic [abc_pkg::HOLD_W-1:0] cnt;
  logic [abc_pkg::HOLD_W-1:0] cnt_inc;
  abc_pkg::frame_t            held;
  logic                       capture;
  logic                       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign cnt_inc = (cnt == {abc_pkg::HOLD_W{1'b1}}) ? cnt : cnt + 1'b1;
  assign capture = (hold_period == '0) || (cnt_inc >= hold_period);

  assign q_push  = accept;
  assign q_frame = capture ? in_frame : held;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= {abc_pkg::HOLD_W{1'b1}};
      held <= '0;
    end else if (accept) begin
      if (capture) begin
        cnt  <= '0;
        held <= in_frame;
      end else begin
        cnt <= cnt_inc;
      end
    end
  end

endmodule

// ===== rtl/abc_queue.sv =====
module abc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  abc_pkg::frame_t push_frame,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output abc_pkg::frame_t pop_frame
);

  abc_pkg::frame_t                 mem [abc_pkg::QUEUE_DEPTH];
  logic [abc_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [abc_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [abc_pkg::QUEUE_AW:0]      count;

  assign full      = (count == (abc_pkg::QUEUE_AW + 1)'(abc_pkg::QUEUE_DEPTH));
  assign valid     = (count != '0);
  assign pop_frame = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == abc_pkg::QUEUE_AW'(abc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= (rd_ptr == abc_pkg::QUEUE_AW'(abc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (abc_pkg::QUEUE_AW + 1)'(push && !full)
                     - (abc_pkg::QUEUE_AW + 1)'(pop && valid);
    end
  end

endmodule

// ===== rtl/abc_back.sv =====
module abc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [abc_pkg::CRUSH_W-1:0]  crush_bits,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  abc_pkg::frame_t              q_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output abc_pkg::frame_t              out_frame
);

  localparam int SB = abc_pkg::SAMPLE_BITS;
  localparam int QB = abc_pkg::QUO_BITS;
  localparam int NW = 2 * SB + 1;
  localparam int DW = 2 * SB;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_LEVEL = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [abc_pkg::DIV_CW-1:0]   div_cnt;

  abc_pkg::sample_t             smp   [abc_pkg::CHANNELS];
  logic [NW-1:0]                n2    [abc_pkg::CHANNELS];
  abc_pkg::sample_t             level [abc_pkg::CHANNELS];
  abc_pkg::sample_t             rem   [abc_pkg::CHANNELS];
  logic [QB-1:0]                low   [abc_pkg::CHANNELS];
  logic [QB-1:0]                quo   [abc_pkg::CHANNELS];
  abc_pkg::frame_t              result;

  logic [abc_pkg::CRUSH_W-1:0]  b_eff;
  logic [SB:0]                  m_full;
  abc_pkg::sample_t             m_val;
  logic                         out_load;

  logic [NW-1:0]                n2_val    [abc_pkg::CHANNELS];
  abc_pkg::sample_t             level_val [abc_pkg::CHANNELS];
  abc_pkg::sample_t             rem_init  [abc_pkg::CHANNELS];
  logic [QB-1:0]                low_init  [abc_pkg::CHANNELS];
  abc_pkg::sample_t             rem_step  [abc_pkg::CHANNELS];
  logic [QB-1:0]                low_step  [abc_pkg::CHANNELS];
  logic [QB-1:0]                quo_step  [abc_pkg::CHANNELS];

  assign b_eff  = (crush_bits > abc_pkg::CRUSH_W'(SB)) ? abc_pkg::CRUSH_W'(SB) : crush_bits;
  assign m_full = ((SB + 1)'(1) << b_eff) - (SB + 1)'(1);
  assign m_val  = m_full[SB-1:0];

  always_comb begin
    abc_pkg::sample_t u;
    logic [NW-1:0]    uw;
    logic [SB:0]      q1;
    logic [SB+1:0]    r1;
    logic [1:0]       q2;
    logic [SB:0]      r2;
    logic [SB:0]      lsum;
    logic [DW-1:0]    dvd;
    logic [SB:0]      t;
    abc_pkg::sample_t r;
    logic [QB-1:0]    l;
    logic [QB-1:0]    q;
    for (int c = 0; c < abc_pkg::CHANNELS; c++) begin
      // Offset binary, then u*m + half step.
      u         = {~smp[c][SB-1], smp[c][SB-2:0]};
      uw        = NW'(u);
      n2_val[c] = (uw << b_eff) - uw + NW'({1'b0, {(SB-1){1'b1}}});

      // Division by 2^SB-1 by folding the upper half into the lower half.
      q1   = n2[c][NW-1:SB];
      r1   = (SB + 2)'(n2[c][SB-1:0]) + (SB + 2)'(q1);
      q2   = r1[SB+1:SB];
      r2   = (SB + 1)'(r1[SB-1:0]) + (SB + 1)'(q2);
      lsum = q1 + (SB + 1)'(q2) + (SB + 1)'(r2 >= (SB + 1)'({SB{1'b1}}));
      level_val[c] = lsum[SB-1:0];

      // Dividend level*(2^SB-1) + (m-1)/2 for the divide by m.
      dvd = {level[c], {SB{1'b0}}} - DW'(level[c]) + DW'(m_val >> 1);
      rem_init[c] = SB'(dvd >> QB);
      low_init[c] = dvd[QB-1:0];

      r = rem[c];
      l = low[c];
      q = quo[c];
      for (int k = 0; k < 2; k++) begin
        t = {r, l[QB-1]};
        l = {l[QB-2:0], 1'b0};
        if (t >= {1'b0, m_val}) begin
          t = t - {1'b0, m_val};
          q = {q[QB-2:0], 1'b1};
        end else begin
          q = {q[QB-2:0], 1'b0};
        end
        r = t[SB-1:0];
      end
      rem_step[c] = r;
      low_step[c] = l;
      quo_step[c] = q;
    end
  end

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (crush_bits == '0) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP:  state_next = ST_LEVEL;
      ST_LEVEL: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int c = 0; c < abc_pkg::CHANNELS; c++) begin
      if (crush_bits == '0) begin
        result[c] = smp[c];
      end else begin
        result[c] = {~quo[c][SB-1], quo[c][SB-2:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        div_cnt <= abc_pkg::DIV_CW'(abc_pkg::DIV_CYC - 1);
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < abc_pkg::CHANNELS; c++) begin
      if (q_pop) begin
        smp[c] <= q_frame[c];
      end
      if (state == ST_PREP) begin
        n2[c] <= n2_val[c];
      end
      if (state == ST_LEVEL) begin
        level[c] <= level_val[c];
      end
      if (state == ST_LOAD) begin
        rem[c] <= rem_init[c];
        low[c] <= low_init[c];
        quo[c] <= '0;
      end else if (state == ST_DIV) begin
        rem[c] <= rem_step[c];
        low[c] <= low_step[c];
        quo[c] <= quo_step[c];
      end
    end
    if (out_load) begin
      out_frame <= result;
    end
  end

endmodule

// ===== rtl/audio_bit_crusher_unit.sv =====
// Stereo bit crusher: each input item is one frame of signed samples, and each
// frame gives exactly one output item after sample-and-hold decimation and
// optional requantization to 2^crush_bits evenly spaced levels (crush_bits
// capped at 16). The front end accepts a frame whenever its two-entry queue has
// room, so input is taken while the back end works or while a result waits on
// the output. The back end takes one item at a time: with crush_bits at 0 it
// goes from idle to done; with quantization on it steps through prep, level,
// load, divide and done; a per-channel restoring divider retires two quotient
// bits per cycle. Configuration registers are hold_period (index 0) and
// crush_bits (index 1); they should be written only while no item is in flight.
module audio_bit_crusher_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [abc_pkg::DATA_W-1:0]        s_tdata,   // in_ch0, in_ch1
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [abc_pkg::DATA_W-1:0]        m_tdata,   // out_ch0, out_ch1
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [abc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [abc_pkg::HOLD_W-1:0]  hold_period;
  logic [abc_pkg::CRUSH_W-1:0] crush_bits;

  abc_pkg::frame_t in_frame;
  abc_pkg::frame_t push_frame;
  abc_pkg::frame_t pop_frame;
  abc_pkg::frame_t out_frame;
  logic            q_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_period <= '0;
      crush_bits  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abc_pkg::REG_HOLD_PERIOD: hold_period <= cfg_data[abc_pkg::HOLD_W-1:0];
        abc_pkg::REG_CRUSH_BITS:  crush_bits  <= cfg_data[abc_pkg::CRUSH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_frame = s_tdata[abc_pkg::DATA_BITS-1:0];

  abc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hold_period (hold_period),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_frame    (in_frame),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_frame     (push_frame)
  );

  abc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .pop_frame  (pop_frame)
  );

  abc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .crush_bits (crush_bits),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_frame    (pop_frame),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_frame  (out_frame)
  );

  assign m_tdata = abc_pkg::DATA_W'(out_frame);

endmodule

// ===== tb/sv/tb.sv =====
module tb;

  localparam int CHANNELS        = abc_pkg::CHANNELS;
  localparam int SAMPLE_BITS     = abc_pkg::SAMPLE_BITS;
  localparam int DATA_BITS       = abc_pkg::DATA_BITS;
  localparam int DATA_W          = abc_pkg::DATA_W;
  localparam int HOLD_W          = abc_pkg::HOLD_W;
  localparam int CRUSH_W         = abc_pkg::CRUSH_W;
  localparam int CFG_IDX_W       = abc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = abc_pkg::CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = abc_pkg::REG_HOLD_PERIOD;
  localparam logic [CFG_IDX_W-1:0] REG_CRUSH_BITS  = abc_pkg::REG_CRUSH_BITS;

  typedef abc_pkg::sample_t sample_t;
  typedef abc_pkg::frame_t  frame_t;

  localparam int CLK_HALF     = 2;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LEN    = 300;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 45;
  localparam int N_DIRECTED   = 23;

  typedef struct packed {
    logic [HOLD_W-1:0]  hold_val;
    logic [CRUSH_W-1:0] bits_val;
    sample_t            in0;
    sample_t            in1;
    bit                 fixed;
    sample_t            exp0;
    sample_t            exp1;
  } dir_row_t;

  // Rows with fixed set carry their result; the rest are checked against the predictor.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{16'hFFFF, 5'd0,  16'h1234, 16'hA5C3, 1'b1, 16'h1234, 16'hA5C3},
    '{16'hFFFF, 5'd0,  16'h7FFF, 16'h8000, 1'b1, 16'h1234, 16'hA5C3},
    '{16'h0000, 5'd0,  16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
    '{16'h0000, 5'd0,  16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
    '{16'h0000, 5'd16, 16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
    '{16'h0000, 5'd16, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
    '{16'h0000, 5'd16, 16'h5A5A, 16'hA5A5, 1'b1, 16'h5A5A, 16'hA5A5},
    '{16'h0000, 5'd31, 16'h1357, 16'hECA8, 1'b1, 16'h1357, 16'hECA8},
    '{16'h0000, 5'd17, 16'h0001, 16'hFFFE, 1'b1, 16'h0001, 16'hFFFE},
    '{16'h0000, 5'd1,  16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
    '{16'h0000, 5'd1,  16'h0000, 16'hFFFF, 1'b1, 16'h7FFF, 16'h8000},
    '{16'h0000, 5'd2,  16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 5'd8,  16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 5'd15, 16'h1234, 16'hC001, 1'b0, 16'h0000, 16'h0000},
    '{16'h0001, 5'd0,  16'h1111, 16'h2222, 1'b1, 16'h1111, 16'h2222},
    '{16'h0001, 5'd0,  16'h3333, 16'h4444, 1'b1, 16'h3333, 16'h4444},
    '{16'h0002, 5'd0,  16'h5555, 16'h6666, 1'b0, 16'h0000, 16'h0000},
    '{16'h0002, 5'd0,  16'h7777, 16'h0888, 1'b0, 16'h0000, 16'h0000},
    '{16'h0002, 5'd0,  16'h0999, 16'h0AAA, 1'b0, 16'h0000, 16'h0000},
    '{16'h0003, 5'd4,  16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h0003, 5'd4,  16'h4000, 16'hC000, 1'b0, 16'h0000, 16'h0000},
    '{16'h0003, 5'd4,  16'h0123, 16'hFEDC, 1'b0, 16'h0000, 16'h0000},
    '{16'h0003, 5'd4,  16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [HOLD_W-1:0]  hold_cfg;
  logic [CRUSH_W-1:0] bits_cfg;
  sample_t            held_smp [CHANNELS];
  logic [HOLD_W-1:0]  since_capture;

  frame_t crushed_q [$];
  frame_t pinned_frame;
  bit     pinned_en;
  int     errors = 0;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     stall_reqs = 0;
  int     stall_seen = 0;
  int     stall_left = 0;

  audio_bit_crusher_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic sample_t requantize(input sample_t x, input logic [CRUSH_W-1:0] bits);
    logic [63:0] full, u, m, lvl, y;
    int          b;
    b    = (bits > SAMPLE_BITS) ? SAMPLE_BITS : int'(bits);
    full = (64'd1 << SAMPLE_BITS) - 64'd1;
    u    = 64'(x ^ (sample_t'(1) << (SAMPLE_BITS - 1)));
    m    = (64'd1 << b) - 64'd1;
    lvl  = (2 * u * m + full) / (2 * full);
    y    = (2 * lvl * full + m) / (2 * m);
    return sample_t'(y) ^ (sample_t'(1) << (SAMPLE_BITS - 1));
  endfunction

  function automatic frame_t crush_frame(input frame_t f);
    frame_t r;
    bit     grab;
    if (hold_cfg == '0) begin
      grab = 1'b1;
    end else begin
      if (since_capture != '1) since_capture = since_capture + 1'b1;
      grab = (since_capture >= hold_cfg);
    end
    if (grab) begin
      since_capture = '0;
      for (int c = 0; c < CHANNELS; c++) held_smp[c] = f[c];
    end
    for (int c = 0; c < CHANNELS; c++) begin
      r[c] = (bits_cfg != '0) ? requantize(held_smp[c], bits_cfg) : held_smp[c];
    end
    return r;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return sample_t'($urandom_range(0, 255));
      3: return -sample_t'($urandom_range(1, 256));
      default: return sample_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      hold_cfg      = '0;
      bits_cfg      = '0;
      since_capture = '1;
      for (int c = 0; c < CHANNELS; c++) held_smp[c] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HOLD_PERIOD) hold_cfg = cfg_data[HOLD_W-1:0];
        else if (cfg_index == REG_CRUSH_BITS) bits_cfg = cfg_data[CRUSH_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        want = crush_frame(s_tdata[DATA_BITS-1:0]);
        if (pinned_en) want = pinned_frame;
        crushed_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (crushed_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, m_tdata);
          errors++;
        end else begin
          want = crushed_q.pop_front();
          for (int c = 0; c < CHANNELS; c++) begin
            if (m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] !== want[c]) begin
              $display("%0t: out_ch%0d expected %h got %h", $time, c, want[c],
                       m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]);
              errors++;
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_frame(input sample_t a, input sample_t b, input bit fixed,
                            input sample_t e0, input sample_t e1);
    frame_t f;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    f[0] = a;
    f[1] = b;
    pinned_frame = '0;
    pinned_frame[0] = e0;
    pinned_frame[1] = e1;
    pinned_en = fixed;
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(f);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (crushed_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    logic [HOLD_W-1:0]  cur_hold;
    logic [CRUSH_W-1:0] cur_bits;
    logic [HOLD_W-1:0]  new_hold;
    logic [CRUSH_W-1:0] new_bits;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pinned_en     = 1'b0;
    pinned_frame  = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_hold      = '0;
    cur_bits      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].hold_val != cur_hold || DIRECTED[i].bits_val != cur_bits) begin
        settle();
        cur_hold = DIRECTED[i].hold_val;
        cur_bits = DIRECTED[i].bits_val;
        write_reg(REG_HOLD_PERIOD, CFG_DATA_W'(cur_hold));
        write_reg(REG_CRUSH_BITS, CFG_DATA_W'(cur_bits));
      end
      push_frame(DIRECTED[i].in0, DIRECTED[i].in1, DIRECTED[i].fixed,
                 DIRECTED[i].exp0, DIRECTED[i].exp1);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < 5) begin
        send_idle_pct = 38;
        recv_idle_pct = 72;
      end else if (p < 10) begin
        send_idle_pct = 72;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(7))
        0: new_hold = '0;
        1: new_hold = 16'd1;
        2, 3, 4, 5: new_hold = HOLD_W'($urandom_range(2, 6));
        6: new_hold = HOLD_W'($urandom_range(7, 60));
        default: new_hold = '1;
      endcase
      case ($urandom_range(5))
        0: new_bits = '0;
        1: new_bits = CRUSH_W'(SAMPLE_BITS);
        2: new_bits = CRUSH_W'($urandom_range(17, 31));
        default: new_bits = CRUSH_W'($urandom_range(1, 15));
      endcase
      if (p == 0) begin
        new_hold = '0;
        new_bits = '0;
      end else if (p == 1) begin
        new_hold = '0;
        new_bits = CRUSH_W'(SAMPLE_BITS);
      end
      write_reg(REG_HOLD_PERIOD, CFG_DATA_W'(new_hold));
      write_reg(REG_CRUSH_BITS, {(CFG_DATA_W - CRUSH_W)'($urandom), new_bits});
      if ($urandom_range(3) == 0 || p == 2) begin
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
      end
      if (p == 10) stall_reqs++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 11 && k == PHASE_ITEMS / 2) wait_drained();
        push_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && crushed_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/abc_pkg.sv
rtl/abc_front.sv
rtl/abc_queue.sv
rtl/abc_back.sv
rtl/audio_bit_crusher_unit.sv
tb/sv/tb.sv
